[src/encoder_speed_block_average_macros.svh]
// Assertion macros for the encoder speed block average checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ENCODER_SPEED_BLOCK_AVERAGE_MACROS_SVH
`define ENCODER_SPEED_BLOCK_AVERAGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/esba_pkg.sv]
// Shared types and constants of the encoder speed block average.
// Used by every module of the block; depends on nothing else.
package esba_pkg;

  localparam int CHANNELS        = 4;
  localparam int CHAN_W          = $clog2(CHANNELS);
  localparam int SPEED_FRAC_BITS = 8;

  localparam int TICK_W  = 32;
  localparam int STAMP_W = 32;
  localparam int SPEED_W = 48;
  localparam int SUM_W   = 56;
  localparam int CNT_W   = 8;
  localparam int IDLE_W  = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [63:0] SPEED_SCALE = 64'd1000000 << SPEED_FRAC_BITS;
  localparam int SCALE_W    = $clog2(SPEED_SCALE + 64'd1);
  localparam int DELTA_W    = TICK_W + 1;
  localparam int SPD_NUM_W  = DELTA_W + SCALE_W;
  localparam int DIV_NUM_W  = (SPD_NUM_W > SUM_W) ? SPD_NUM_W : SUM_W;
  localparam int DIV_DEN_W  = STAMP_W;
  localparam int DIV_Q_W    = SPEED_W;
  localparam int DIV_HI_W   = DIV_NUM_W - DIV_Q_W;
  localparam int DIV_CNT_W  = $clog2(DIV_Q_W);

  localparam logic [SPEED_W-1:0] SPEED_POS_LIM = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] SPEED_NEG_LIM = {1'b1, {(SPEED_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 8'd10;
  localparam logic [CFG_W-1:0] IDLE_LIMIT_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 1'b1;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_PUBLISH = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [STAMP_W-1:0]       stamp_us;
    logic signed [TICK_W-1:0] ticks_a;
    logic signed [TICK_W-1:0] ticks_b;
    logic signed [TICK_W-1:0] ticks_c;
    logic signed [TICK_W-1:0] ticks_d;
  } esba_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]         channel;
    logic signed [TICK_W-1:0]  position;
    logic signed [SPEED_W-1:0] inst_speed;
    logic                      avg_valid;
    logic signed [SPEED_W-1:0] avg_speed;
    logic                      last;
  } esba_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } esba_div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quo;
  } esba_div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPD_MUL,
    ST_SPD_LOAD,
    ST_SPD_DIV,
    ST_SPD_UPD,
    ST_PUB_EVAL,
    ST_PUB_DIV,
    ST_PUB_EMIT
  } esba_state_e;

endpackage

[src/esba_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on esba_pkg for widths and the request and response structs.
module esba_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esba_pkg::esba_div_req_t req_i,
  output esba_pkg::esba_div_rsp_t rsp_o
);

  localparam int NumW = esba_pkg::DIV_NUM_W;
  localparam int DenW = esba_pkg::DIV_DEN_W;
  localparam int QW   = esba_pkg::DIV_Q_W;
  localparam int HiW  = esba_pkg::DIV_HI_W;
  localparam int CntW = esba_pkg::DIV_CNT_W;
  localparam int CmpW = (HiW > DenW) ? HiW : DenW;

  logic            busy_q;
  logic            done_q;
  logic            ovf_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [QW-1:0]   work_q;

  logic [HiW-1:0]  num_hi;
  logic            ovf_start;
  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;
  logic            q_bit;
  logic [DenW-1:0] rem_nxt;

  // A quotient that does not fit in QW bits shows up as a high part that is
  // not below the divisor.
  assign num_hi    = req_i.num[NumW-1:QW];
  assign ovf_start = CmpW'(num_hi) >= CmpW'(req_i.den);

  assign shifted = {rem_q, work_q[QW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign q_bit   = !diff[DenW];
  assign rem_nxt = q_bit ? diff[DenW-1:0] : shifted[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !ovf_start;
        done_q <= ovf_start;
        cnt_q  <= CntW'(QW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= DenW'(num_hi);
      work_q <= req_i.num[QW-1:0];
      den_q  <= req_i.den;
      ovf_q  <= ovf_start;
    end else if (busy_q) begin
      rem_q  <= rem_nxt;
      work_q <= {work_q[QW-2:0], q_bit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = work_q;

endmodule

[src/encoder_speed_block_average.sv]
// Top level of the four-channel encoder speed estimator with block averaging.
// Depends on esba_pkg and instantiates the shared divider esba_div.
//
// A sample beat (op 0) updates every channel in turn and returns nothing; a
// publish beat (op 1) returns one result beat per channel, channel 0 first.
// The block takes one input beat at a time and is not ready until it has
// finished that beat's work. Every division goes through one shared divider
// that produces one quotient bit per cycle. A sample beat divides once per
// channel when the time step is positive, and a publish beat divides once
// for each channel whose average is computed; a publish beat can also wait
// on the output side. A finished result beat waits in an output register,
// and a new input beat is taken while it waits.
module encoder_speed_block_average (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  esba_pkg::esba_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output esba_pkg::esba_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [esba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [esba_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int Ch      = esba_pkg::CHANNELS;
  localparam int ChW     = esba_pkg::CHAN_W;
  localparam int TickW   = esba_pkg::TICK_W;
  localparam int StampW  = esba_pkg::STAMP_W;
  localparam int SpeedW  = esba_pkg::SPEED_W;
  localparam int SumW    = esba_pkg::SUM_W;
  localparam int CntW    = esba_pkg::CNT_W;
  localparam int IdleW   = esba_pkg::IDLE_W;
  localparam int CfgW    = esba_pkg::CFG_W;
  localparam int DeltaW  = esba_pkg::DELTA_W;
  localparam int SpdNumW = esba_pkg::SPD_NUM_W;
  localparam int DivNumW = esba_pkg::DIV_NUM_W;
  localparam int DivDenW = esba_pkg::DIV_DEN_W;

  esba_pkg::esba_state_e state_q, state_d;
  logic [ChW-1:0]        chan_q, chan_d;

  logic [CfgW-1:0]       window_len_q;
  logic [CfgW-1:0]       idle_limit_q;
  logic [StampW-1:0]     prev_stamp_q;

  logic [TickW-1:0]      prev_ticks_q   [Ch];
  logic [TickW-1:0]      prev_ticks_d   [Ch];
  logic [SpeedW-1:0]     speed_now_q    [Ch];
  logic [SpeedW-1:0]     speed_now_d    [Ch];
  logic [SumW-1:0]       speed_sum_q    [Ch];
  logic [SumW-1:0]       speed_sum_d    [Ch];
  logic [CntW-1:0]       sample_count_q [Ch];
  logic [CntW-1:0]       sample_count_d [Ch];
  logic                  fresh_flag_q   [Ch];
  logic                  fresh_flag_d   [Ch];
  logic [IdleW-1:0]      idle_ticks_q   [Ch];
  logic [IdleW-1:0]      idle_ticks_d   [Ch];

  logic                  out_valid_q, out_valid_d;
  esba_pkg::esba_out_t   out_data_q, out_data_d;

  esba_pkg::esba_in_t    item_q;
  logic                  dt_pos_q;
  logic [StampW-1:0]     dt_q;
  logic                  neg_q;
  logic [SpdNumW-1:0]    prod_q;

  esba_pkg::esba_div_req_t div_req;
  esba_pkg::esba_div_rsp_t div_rsp;

  logic                  in_acc;
  logic [StampW:0]       stamp_diff;
  logic [TickW-1:0]      cur_ticks;
  logic [DeltaW-1:0]     delta;
  logic [DeltaW-1:0]     delta_abs;
  logic [SpeedW-1:0]     spd_lim;
  logic [SpeedW-1:0]     spd_mag;
  logic [SpeedW-1:0]     spd_val;
  logic [SumW-1:0]       sum_cur;
  logic                  sum_neg;
  logic [SumW-1:0]       sum_mag;
  logic [SpeedW-1:0]     avg_val;
  logic                  wl_nz;
  logic                  need_avg;
  logic [IdleW-1:0]      idle_inc;
  logic                  last_chan;
  logic                  out_free;

  esba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == esba_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign stamp_diff = {1'b0, in_data_i.stamp_us} - {1'b0, prev_stamp_q};

  always_comb begin
    case (chan_q)
      ChW'(0):  cur_ticks = item_q.ticks_a;
      ChW'(1):  cur_ticks = item_q.ticks_b;
      ChW'(2):  cur_ticks = item_q.ticks_c;
      ChW'(3):  cur_ticks = item_q.ticks_d;
      default:  cur_ticks = '0;
    endcase
  end

  assign delta     = {cur_ticks[TickW-1], cur_ticks}
                   - {prev_ticks_q[chan_q][TickW-1], prev_ticks_q[chan_q]};
  assign delta_abs = delta[DeltaW-1] ? (DeltaW'(0) - delta) : delta;

  assign spd_lim = neg_q ? esba_pkg::SPEED_NEG_LIM : esba_pkg::SPEED_POS_LIM;
  assign spd_mag = (div_rsp.ovf || (div_rsp.quo > spd_lim)) ? spd_lim : div_rsp.quo;
  assign spd_val = !dt_pos_q ? '0 : (neg_q ? (SpeedW'(0) - spd_mag) : spd_mag);

  assign sum_cur = speed_sum_q[chan_q];
  assign sum_neg = sum_cur[SumW-1];
  assign sum_mag = sum_neg ? (SumW'(0) - sum_cur) : sum_cur;
  assign avg_val = sum_neg ? (SpeedW'(0) - div_rsp.quo) : div_rsp.quo;

  assign wl_nz     = (window_len_q != '0);
  assign need_avg  = wl_nz && fresh_flag_q[chan_q]
                     && (sample_count_q[chan_q] >= window_len_q);
  assign idle_inc  = (idle_ticks_q[chan_q] == '1) ? idle_ticks_q[chan_q]
                                                  : idle_ticks_q[chan_q] + IdleW'(1);
  assign last_chan = (chan_q == ChW'(Ch - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    div_req.start = ((state_q == esba_pkg::ST_SPD_LOAD) && dt_pos_q)
                    || ((state_q == esba_pkg::ST_PUB_EVAL) && need_avg);
    if (state_q == esba_pkg::ST_PUB_EVAL) begin
      div_req.num = DivNumW'(sum_mag);
      div_req.den = DivDenW'(sample_count_q[chan_q]);
    end else begin
      div_req.num = DivNumW'(prod_q);
      div_req.den = dt_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    chan_d         = chan_q;
    prev_ticks_d   = prev_ticks_q;
    speed_now_d    = speed_now_q;
    speed_sum_d    = speed_sum_q;
    sample_count_d = sample_count_q;
    fresh_flag_d   = fresh_flag_q;
    idle_ticks_d   = idle_ticks_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_data_d     = out_data_q;

    unique case (state_q)
      esba_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          chan_d  = '0;
          state_d = (in_data_i.op == esba_pkg::OP_SAMPLE) ? esba_pkg::ST_SPD_MUL
                                                          : esba_pkg::ST_PUB_EVAL;
        end
      end
      esba_pkg::ST_SPD_MUL: begin
        state_d = esba_pkg::ST_SPD_LOAD;
      end
      esba_pkg::ST_SPD_LOAD: begin
        state_d = dt_pos_q ? esba_pkg::ST_SPD_DIV : esba_pkg::ST_SPD_UPD;
      end
      esba_pkg::ST_SPD_DIV: begin
        if (div_rsp.done) begin
          state_d = esba_pkg::ST_SPD_UPD;
        end
      end
      esba_pkg::ST_SPD_UPD: begin
        prev_ticks_d[chan_q] = cur_ticks;
        speed_now_d[chan_q]  = spd_val;
        if (wl_nz && (sample_count_q[chan_q] != '1)) begin
          speed_sum_d[chan_q]    = speed_sum_q[chan_q]
                                   + {{(SumW - SpeedW){spd_val[SpeedW-1]}}, spd_val};
          sample_count_d[chan_q] = sample_count_q[chan_q] + CntW'(1);
        end
        fresh_flag_d[chan_q] = 1'b1;
        idle_ticks_d[chan_q] = '0;
        if (last_chan) begin
          state_d = esba_pkg::ST_IDLE;
        end else begin
          chan_d  = chan_q + ChW'(1);
          state_d = esba_pkg::ST_SPD_MUL;
        end
      end
      esba_pkg::ST_PUB_EVAL: begin
        state_d = need_avg ? esba_pkg::ST_PUB_DIV : esba_pkg::ST_PUB_EMIT;
      end
      esba_pkg::ST_PUB_DIV: begin
        if (div_rsp.done) begin
          state_d = esba_pkg::ST_PUB_EMIT;
        end
      end
      esba_pkg::ST_PUB_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.channel    = chan_q;
          out_data_d.position   = prev_ticks_q[chan_q];
          out_data_d.inst_speed = speed_now_q[chan_q];
          out_data_d.avg_valid  = wl_nz && (fresh_flag_q[chan_q] ? need_avg
                                                                 : (idle_inc >= idle_limit_q));
          out_data_d.avg_speed  = need_avg ? avg_val : '0;
          out_data_d.last       = last_chan;
          speed_now_d[chan_q]   = '0;
          fresh_flag_d[chan_q]  = 1'b0;
          if (wl_nz) begin
            if (!fresh_flag_q[chan_q]) begin
              idle_ticks_d[chan_q] = idle_inc;
            end else begin
              idle_ticks_d[chan_q] = '0;
            end
          end
          if (need_avg) begin
            speed_sum_d[chan_q]    = '0;
            sample_count_d[chan_q] = '0;
          end
          if (last_chan) begin
            state_d = esba_pkg::ST_IDLE;
          end else begin
            chan_d  = chan_q + ChW'(1);
            state_d = esba_pkg::ST_PUB_EVAL;
          end
        end
      end
      default: begin
        state_d = esba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= esba_pkg::ST_IDLE;
      chan_q       <= '0;
      window_len_q <= esba_pkg::WINDOW_LEN_RST;
      idle_limit_q <= esba_pkg::IDLE_LIMIT_RST;
      prev_stamp_q <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < Ch; i++) begin
        prev_ticks_q[i]   <= '0;
        speed_now_q[i]    <= '0;
        speed_sum_q[i]    <= '0;
        sample_count_q[i] <= '0;
        fresh_flag_q[i]   <= 1'b0;
        idle_ticks_q[i]   <= '0;
      end
    end else begin
      state_q        <= state_d;
      chan_q         <= chan_d;
      out_valid_q    <= out_valid_d;
      prev_ticks_q   <= prev_ticks_d;
      speed_now_q    <= speed_now_d;
      speed_sum_q    <= speed_sum_d;
      sample_count_q <= sample_count_d;
      fresh_flag_q   <= fresh_flag_d;
      idle_ticks_q   <= idle_ticks_d;
      if (in_acc && (in_data_i.op == esba_pkg::OP_SAMPLE)) begin
        prev_stamp_q <= in_data_i.stamp_us;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          esba_pkg::CFG_WINDOW_LEN: window_len_q <= cfg_data_i;
          esba_pkg::CFG_IDLE_LIMIT: idle_limit_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_acc) begin
      item_q   <= in_data_i;
      dt_pos_q <= !stamp_diff[StampW] && (stamp_diff[StampW-1:0] != '0);
      dt_q     <= stamp_diff[StampW-1:0];
    end
    if (state_q == esba_pkg::ST_SPD_MUL) begin
      neg_q  <= delta[DeltaW-1];
      prod_q <= SpdNumW'(delta_abs) * SpdNumW'(esba_pkg::SPEED_SCALE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[src/esba_checker.sv]
// Port-level checks of the encoder speed block average, bound to the top level.
// Depends on esba_pkg and the assertion macros header.
`include "encoder_speed_block_average_macros.svh"

module esba_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input esba_pkg::esba_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input esba_pkg::esba_out_t out_data_o
);

  localparam logic [esba_pkg::CHAN_W-1:0] LastChan = esba_pkg::CHAN_W'(esba_pkg::CHANNELS - 1);

  logic in_beat;
  logic in_op_seen;

  assign in_beat    = in_valid_i && in_ready_o;
  assign in_op_seen = in_data_i.op == esba_pkg::OP_PUBLISH || in_data_i.op == esba_pkg::OP_SAMPLE;

  `ESBA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat dropped or changed while stalled")
  `ESBA_ASSERT_IMP(a_avg_zero, out_valid_o && !out_data_o.avg_valid, out_data_o.avg_speed == '0, "average speed not zero without a valid average")
  `ESBA_ASSERT_IMP(a_last_chan, out_valid_o, out_data_o.last == (out_data_o.channel == LastChan), "last flag does not match the final channel")
  `ESBA_ASSERT_NXT(a_busy_after_beat, in_beat && in_op_seen, !in_ready_o, "input ready right after an accepted beat")

endmodule

bind encoder_speed_block_average esba_checker u_esba_checker (.*);
